// ===== hdl/pvf_pkg.sv =====
// ----------------------------------------------------------------------------
// pvf_pkg
// Shared constants for the peak and valley flagger: default sizes, slope sign
// codes, sign change codes and result kind codes.
// ----------------------------------------------------------------------------
package pvf_pkg;

  // default sizes
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int MAX_FRAME_DEF   = 4096;

  // result index field
  localparam int INDEX_BITS = 12;
  localparam int INDEX_MAX  = (1 << INDEX_BITS) - 1;

  // slope sign, two's complement -1 / 0 / +1
  localparam logic [1:0] SIGN_ZERO = 2'b00;
  localparam logic [1:0] SIGN_POS  = 2'b01;
  localparam logic [1:0] SIGN_NEG  = 2'b11;

  // change of slope sign, three bit two's complement
  localparam logic [2:0] CHG_FALL2 = 3'b110;
  localparam logic [2:0] CHG_RISE1 = 3'b001;
  localparam logic [2:0] CHG_RISE2 = 3'b010;

  // result kinds
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_PEAK   = 2'd1;
  localparam logic [1:0] KIND_HALF   = 2'd2;
  localparam logic [1:0] KIND_VALLEY = 2'd3;

endpackage

// ===== hdl/pvf_in_if.sv =====
// ----------------------------------------------------------------------------
// pvf_in_if
// Sample request channel: valid/ready handshake with one signed sample and
// the end of frame marker.
// ----------------------------------------------------------------------------
interface pvf_in_if #(
  parameter int SAMPLE_BITS = pvf_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last_in_frame;

  modport source (output valid, output sample, output last_in_frame, input ready);
  modport sink   (input valid, input sample, input last_in_frame, output ready);
endinterface

// ===== hdl/pvf_out_if.sv =====
// ----------------------------------------------------------------------------
// pvf_out_if
// Flag request channel: valid/ready handshake with the flagged kind and
// position and the running extremes of the frame.
// ----------------------------------------------------------------------------
interface pvf_out_if #(
  parameter int SAMPLE_BITS = pvf_pkg::SAMPLE_BITS_DEF
);
  logic                           valid;
  logic                           ready;
  logic [1:0]                     flag_kind;
  logic [pvf_pkg::INDEX_BITS-1:0] flag_index;
  logic                           frame_done;
  logic signed [SAMPLE_BITS-1:0]  max_value;
  logic                           max_found;
  logic signed [SAMPLE_BITS-1:0]  min_value;
  logic                           min_found;

  modport source (
    output valid, output flag_kind, output flag_index, output frame_done,
    output max_value, output max_found, output min_value, output min_found,
    input ready
  );
  modport sink (
    input valid, input flag_kind, input flag_index, input frame_done,
    input max_value, input max_found, input min_value, input min_found,
    output ready
  );
endinterface

// ===== hdl/peak_valley_flagger.sv =====
// ----------------------------------------------------------------------------
// peak_valley_flagger
// Slope sign change detector over frames of signed samples. Flags peaks,
// half-peaks and valleys and tracks the frame's largest peak and smallest
// valley.
// ----------------------------------------------------------------------------
//
//   channel   dir  carries
//   --------  ---  -------------------------------------------------------
//   samples   in   sample, last_in_frame
//   flags     out  flag_kind, flag_index, frame_done, max/min value + found
//
// One sample is taken every cycle while samples.ready is high; its flag enters
// the output buffer. The first sample of a longer frame gives no flag.
// The output side is a two-entry buffer (output register plus skid register);
// samples.ready drops only while both entries hold undelivered flags.
// Reset (rst, synchronous) empties the buffer and starts a new frame.
// ----------------------------------------------------------------------------
module peak_valley_flagger #(
  parameter int SAMPLE_BITS = pvf_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_FRAME   = pvf_pkg::MAX_FRAME_DEF
) (
  input logic       clk,
  input logic       rst,
  pvf_in_if.sink    samples,
  pvf_out_if.source flags
);
  import pvf_pkg::*;

  localparam int POS_LIMIT_INT = (MAX_FRAME - 1 > INDEX_MAX) ? INDEX_MAX : MAX_FRAME - 1;
  localparam int POS_BITS      = (POS_LIMIT_INT < 2) ? 1 : $clog2(POS_LIMIT_INT + 1);
  localparam logic [POS_BITS-1:0] POS_LIMIT = POS_BITS'(POS_LIMIT_INT);

  typedef struct packed {
    logic [1:0]             flag_kind;
    logic [INDEX_BITS-1:0]  flag_index;
    logic                   frame_done;
    logic [SAMPLE_BITS-1:0] max_value;
    logic                   max_found;
    logic [SAMPLE_BITS-1:0] min_value;
    logic                   min_found;
  } result_t;

  // frame state
  logic signed [SAMPLE_BITS-1:0] prev_sample;
  logic [1:0]                    prev_sign;
  logic                          frame_start;
  logic [POS_BITS-1:0]           position;
  logic signed [SAMPLE_BITS-1:0] run_max;
  logic                          max_seen;
  logic signed [SAMPLE_BITS-1:0] run_min;
  logic                          min_seen;

  // output buffer
  logic    out_valid;
  result_t out_data;
  logic    skid_valid;
  result_t skid_data;

  logic                          accept;
  logic                          has_result;
  logic signed [SAMPLE_BITS:0]   slope;
  logic [1:0]                    cur_sign;
  logic [2:0]                    change;
  logic [1:0]                    kind;
  logic signed [SAMPLE_BITS-1:0] run_max_next;
  logic                          max_seen_next;
  logic signed [SAMPLE_BITS-1:0] run_min_next;
  logic                          min_seen_next;
  logic [POS_BITS-1:0]           position_next;
  result_t                       result;
  logic                          push;
  logic                          pop;

  assign samples.ready = ~skid_valid;
  assign accept        = samples.valid & samples.ready;

  // slope sign and change of sign
  always_comb begin
    slope = {samples.sample[SAMPLE_BITS-1], samples.sample}
          - {prev_sample[SAMPLE_BITS-1], prev_sample};
    if (slope[SAMPLE_BITS]) begin
      cur_sign = SIGN_NEG;
    end else if (|slope) begin
      cur_sign = SIGN_POS;
    end else begin
      cur_sign = SIGN_ZERO;
    end
    change = {cur_sign[1], cur_sign} - {prev_sign[1], prev_sign};
  end

  // classify the previous sample, or a lone sample by its own sign
  always_comb begin
    kind = KIND_NONE;
    if (frame_start) begin
      if (cur_sign == SIGN_POS) begin
        kind = KIND_PEAK;
      end else if (cur_sign == SIGN_NEG) begin
        kind = KIND_VALLEY;
      end
    end else begin
      unique case (change)
        CHG_FALL2: kind = KIND_PEAK;
        CHG_RISE1: kind = KIND_HALF;
        CHG_RISE2: kind = KIND_VALLEY;
        default:   kind = KIND_NONE;
      endcase
    end
  end

  // running extremes
  always_comb begin
    run_max_next  = run_max;
    max_seen_next = max_seen;
    run_min_next  = run_min;
    min_seen_next = min_seen;
    if (!frame_start && (kind == KIND_PEAK || kind == KIND_HALF)) begin
      if (!max_seen || prev_sample > run_max) begin
        run_max_next = prev_sample;
      end
      max_seen_next = 1'b1;
    end
    if (!frame_start && kind == KIND_VALLEY) begin
      if (!min_seen || prev_sample < run_min) begin
        run_min_next = prev_sample;
      end
      min_seen_next = 1'b1;
    end
  end

  // saturating position
  always_comb begin
    if (frame_start) begin
      position_next = '0;
    end else if (position < POS_LIMIT) begin
      position_next = position + 1'b1;
    end else begin
      position_next = position;
    end
  end

  // result payload
  always_comb begin
    has_result        = ~frame_start | samples.last_in_frame;
    result.flag_kind  = kind;
    result.flag_index = frame_start ? '0 : INDEX_BITS'(position);
    result.frame_done = samples.last_in_frame;
    result.max_value  = run_max_next;
    result.max_found  = max_seen_next;
    result.min_value  = run_min_next;
    result.min_found  = min_seen_next;
  end

  // frame state update
  always_ff @(posedge clk) begin
    if (rst || (accept && samples.last_in_frame)) begin
      prev_sample <= '0;
      prev_sign   <= SIGN_ZERO;
      frame_start <= 1'b1;
      position    <= '0;
      run_max     <= '0;
      max_seen    <= 1'b0;
      run_min     <= '0;
      min_seen    <= 1'b0;
    end else if (accept) begin
      prev_sample <= samples.sample;
      prev_sign   <= cur_sign;
      frame_start <= 1'b0;
      position    <= position_next;
      run_max     <= run_max_next;
      max_seen    <= max_seen_next;
      run_min     <= run_min_next;
      min_seen    <= min_seen_next;
    end
  end

  // two-entry output buffer
  assign push = accept & has_result;
  assign pop  = out_valid & flags.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      if (!out_valid) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_valid) begin
      out_data <= skid_data;
    end else if (push && (pop || !out_valid)) begin
      out_data <= result;
    end
    if (push && out_valid && !pop) begin
      skid_data <= result;
    end
  end

  assign flags.valid      = out_valid;
  assign flags.flag_kind  = out_data.flag_kind;
  assign flags.flag_index = out_data.flag_index;
  assign flags.frame_done = out_data.frame_done;
  assign flags.max_value  = out_data.max_value;
  assign flags.max_found  = out_data.max_found;
  assign flags.min_value  = out_data.min_value;
  assign flags.min_found  = out_data.min_found;

endmodule

// ===== hdl/pvf_checker.sv =====
// ----------------------------------------------------------------------------
// pvf_checker
// Port-level checks for the peak and valley flagger, bound to its top level.
// ----------------------------------------------------------------------------
module pvf_checker #(
  parameter int SAMPLE_BITS = pvf_pkg::SAMPLE_BITS_DEF
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [1:0]                     flag_kind,
  input logic [pvf_pkg::INDEX_BITS-1:0] flag_index,
  input logic                           frame_done,
  input logic [SAMPLE_BITS-1:0]         max_value,
  input logic                           max_found,
  input logic [SAMPLE_BITS-1:0]         min_value,
  input logic                           min_found
);
  import pvf_pkg::*;

  // buffer is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("flag request pending after reset");

  // a stalled request holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(flag_kind) && $stable(flag_index)
      && $stable(frame_done) && $stable(max_value) && $stable(min_value))
    else $error("stalled flag request changed");

  // no maximum reported before one was found
  a_max_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !max_found |-> max_value == '0)
    else $error("max value without a peak");

  // no minimum reported before one was found
  a_min_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !min_found |-> min_value == '0)
    else $error("min value without a valley");

  // a peak or half-peak inside a frame always sets the maximum
  a_peak_sets_max: assert property (@(posedge clk) disable iff (rst)
    out_valid && (flag_kind == KIND_PEAK || flag_kind == KIND_HALF)
      && !(frame_done && flag_index == '0) |-> max_found)
    else $error("peak without max update");

endmodule

bind peak_valley_flagger pvf_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_pvf_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (flags.valid),
  .out_ready  (flags.ready),
  .flag_kind  (flags.flag_kind),
  .flag_index (flags.flag_index),
  .frame_done (flags.frame_done),
  .max_value  (flags.max_value),
  .max_found  (flags.max_found),
  .min_value  (flags.min_value),
  .min_found  (flags.min_found)
);
